FILE: rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg: shared types and constants
// Request payload types, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } aavr_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } aavr_out_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
    logic               neg;
  } aavr_cordic_t;

  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] r;
    begin
      case (i)
        0:       r = 36'sd843314857;
        1:       r = 36'sd497837829;
        2:       r = 36'sd263043837;
        3:       r = 36'sd133525159;
        4:       r = 36'sd67021687;
        5:       r = 36'sd33543516;
        6:       r = 36'sd16775851;
        7:       r = 36'sd8388437;
        8:       r = 36'sd4194283;
        9:       r = 36'sd2097149;
        10:      r = 36'sd1048576;
        default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) : 36'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/aavr_cordic_stage.sv
// ----------------------------------------------------------------------------
// aavr_cordic_stage: one rotation-mode CORDIC iteration
// Combinational micro-rotation by a fixed stage index.
// ----------------------------------------------------------------------------
module aavr_cordic_stage (
  input  logic [4:0]             idx,
  input  aavr_pkg::aavr_cordic_t d_in,
  output aavr_pkg::aavr_cordic_t d_out
);
  import aavr_pkg::*;

  logic signed [35:0] xs, ys, at;

  always_comb begin
    xs = d_in.x >>> idx;
    ys = d_in.y >>> idx;
    at = atan_q30(int'(idx));
    d_out.neg = d_in.neg;
    if (!d_in.z[35]) begin
      d_out.x = d_in.x - ys;
      d_out.y = d_in.y + xs;
      d_out.z = d_in.z - at;
    end else begin
      d_out.x = d_in.x + ys;
      d_out.y = d_in.y - xs;
      d_out.z = d_in.z + at;
    end
  end

endmodule

FILE: rtl/axis_angle_vector_rotate.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate: Rodrigues rotation of a vector about a unit axis
// A request passes the angle-fold register, the CORDIC registers, P1 to P4
// and the output register; one request per cycle is accepted unless the
// output is stalled. A pipeline-wide stall holds every stage and the output
// register. Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aavr_pkg::aavr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aavr_pkg::aavr_out_t out_data
);
  import aavr_pkg::*;

  localparam int CS = (CORDIC_STAGES + 1) / 2;
  localparam int NS = CS + 6;

  logic adv;
  logic [NS-1:0] vld_r;
  aavr_in_t req_r [CS+1];
  aavr_cordic_t cor_r [CS+1];
  aavr_cordic_t cor_a [CS];
  aavr_cordic_t cor_b [CS];

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r[0] <= in_data;
      for (int i = 1; i <= CS; i++) req_r[i] <= req_r[i-1];
    end
  end

  // Stage 0: fold the angle into +-pi/2.
  logic signed [35:0] z0;
  assign z0 = 36'(in_data.angle) <<< 17;
  always_ff @(posedge clk) begin
    if (adv) begin
      cor_r[0].x <= Q30_GAIN;
      cor_r[0].y <= '0;
      if (z0 > Q30_HALF_PI) begin
        cor_r[0].z <= z0 - Q30_PI; cor_r[0].neg <= 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
        cor_r[0].z <= z0 + Q30_PI; cor_r[0].neg <= 1'b1;
      end else begin
        cor_r[0].z <= z0; cor_r[0].neg <= 1'b0;
      end
    end
  end

  // Two CORDIC iterations per register stage.
  for (genvar g = 0; g < CS; g++) begin : g_cor
    aavr_cordic_t mid;
    aavr_cordic_stage u_a (.idx(5'(2*g)), .d_in(cor_r[g]), .d_out(cor_a[g]));
    aavr_cordic_stage u_b (.idx(5'(2*g+1)), .d_in(cor_a[g]), .d_out(cor_b[g]));
    assign mid = (2*g+1 < CORDIC_STAGES) ? cor_b[g] : cor_a[g];
    always_ff @(posedge clk) begin
      if (adv) cor_r[g+1] <= mid;
    end
  end

  // Sine and cosine in Q1.14; products are staged after the CORDIC.
  aavr_cordic_t cf;
  logic signed [19:0] c_w, s_w;
  assign cf = cor_r[CS];
  always_comb begin
    c_w = 20'((cf.x + 36'sd32768) >>> 16);
    s_w = 20'((cf.y + 36'sd32768) >>> 16);
    if (cf.neg) begin
      c_w = -c_w; s_w = -s_w;
    end
  end

  aavr_in_t q;
  assign q = req_r[CS];

  logic signed [19:0] c_r, s_r, c_r2, s_r2, c_r3;
  logic signed [49:0] p_r [3][6];
  logic signed [51:0] cr_r [3];
  logic signed [51:0] dot_r;
  logic signed [31:0] v_r [3], v_r2 [3];
  logic signed [15:0] k_r [3], k_r2 [3];
  logic signed [37:0] d16;
  logic signed [71:0] t2p_r [3];
  logic signed [55:0] kd_r [3];
  logic signed [19:0] omc;
  logic signed [55:0] t1_r [3], t2_r [3];
  logic signed [47:0] kd14 [3];
  logic signed [71:0] t3_r [3];
  logic signed [55:0] t1_r4 [3];
  logic signed [73:0] sum [3];
  logic signed [59:0] r [3];
  logic signed [31:0] o_w [3];
  aavr_out_t res;

  always_comb begin
    for (int j = 0; j < 3; j++) kd14[j] = 48'((kd_r[j] + 56'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // P1: raw products k*v.
      c_r <= c_w; s_r <= s_w;
      v_r[0] <= q.in_x; v_r[1] <= q.in_y; v_r[2] <= q.in_z;
      k_r[0] <= q.axis_x; k_r[1] <= q.axis_y; k_r[2] <= q.axis_z;
      p_r[0][0] <= 50'(q.axis_y) * 50'(q.in_z);
      p_r[0][1] <= 50'(q.axis_z) * 50'(q.in_y);
      p_r[1][0] <= 50'(q.axis_z) * 50'(q.in_x);
      p_r[1][1] <= 50'(q.axis_x) * 50'(q.in_z);
      p_r[2][0] <= 50'(q.axis_x) * 50'(q.in_y);
      p_r[2][1] <= 50'(q.axis_y) * 50'(q.in_x);
      p_r[0][2] <= 50'(q.axis_x) * 50'(q.in_x);
      p_r[1][2] <= 50'(q.axis_y) * 50'(q.in_y);
      p_r[2][2] <= 50'(q.axis_z) * 50'(q.in_z);
      // P2: cross and dot sums.
      c_r2 <= c_r; s_r2 <= s_r;
      for (int j = 0; j < 3; j++) begin
        v_r2[j] <= v_r[j]; k_r2[j] <= k_r[j];
        cr_r[j] <= 52'(p_r[j][0]) - 52'(p_r[j][1]);
      end
      dot_r <= 52'(p_r[0][2]) + 52'(p_r[1][2]) + 52'(p_r[2][2]);
      // P3: products with c, s and d16.
      c_r3 <= c_r2;
      for (int j = 0; j < 3; j++) begin
        t2p_r[j] <= 72'(cr_r[j]) * 72'(s_r2);
        kd_r[j] <= 56'(k_r2[j]) * 56'(d16);
        t1_r[j] <= 56'(v_r2[j]) * 56'(c_r2);
      end
      // P4: round and multiply by 1-cos.
      for (int j = 0; j < 3; j++) begin
        t1_r4[j] <= t1_r[j];
        t2_r[j] <= 56'((t2p_r[j] + 72'sd8192) >>> 14);
        t3_r[j] <= 72'(kd14[j]) * 72'(omc);
      end
    end
  end

  assign d16 = 38'((dot_r + 52'sd8192) >>> 14);
  assign omc = 20'sd16384 - c_r3;

  // P5: final sum, round and clamp into the output register.
  always_comb begin
    res.saturated = 1'b0;
    for (int j = 0; j < 3; j++) begin
      sum[j] = 74'(t1_r4[j]) + 74'(t2_r[j]) + 74'(t3_r[j]);
      r[j] = 60'((sum[j] + 74'sd8192) >>> 14);
    end
    for (int j = 0; j < 3; j++) begin
      if (r[j] > 60'sd2147483647) begin
        o_w[j] = 32'h7fffffff; res.saturated = 1'b1;
      end else if (r[j] < -60'sd2147483648) begin
        o_w[j] = 32'h80000000; res.saturated = 1'b1;
      end else begin
        o_w[j] = r[j][31:0];
      end
    end
    res.out_x = o_w[0];
    res.out_y = o_w[1];
    res.out_z = o_w[2];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res;
  end

  assign out_valid = vld_r[NS-1];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && in_valid && !out_stall |=> vld_r[0])
    else $error("accepted request lost");
`endif

endmodule

FILE: tb/sv/tb_axis_angle_vector_rotate.sv
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotate: self-checking bench for the Rodrigues rotator
// Random and corner-case vectors, axes and angles are sent through the block
// with random gaps and stalls; each result is checked against a local
// fixed-point model of the CORDIC and the rotation formula.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotate;
  timeunit 1ns;
  timeprecision 1ps;
  import aavr_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  aavr_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  aavr_out_t out_data;

  axis_angle_vector_rotate dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  aavr_in_t  pending_reqs[$];
  aavr_out_t expected_rot[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  bit        in_taken;
  int        mismatches;
  longint    cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    longint tab[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tab[i];
    return 64'sd1 << (30 - i);
  endfunction

  function automatic aavr_out_t rotate_vector(aavr_in_t r);
    longint v[3], k[3], cr[3];
    longint z, x, y, xs, ys, c, s, omc, dot, d16, t1, t2, t3, sum;
    bit neg;
    aavr_out_t o;
    v[0] = r.in_x; v[1] = r.in_y; v[2] = r.in_z;
    k[0] = r.axis_x; k[1] = r.axis_y; k[2] = r.axis_z;
    z = longint'(r.angle) * 131072;
    x = 652032874;
    y = 0;
    neg = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    c = round_shift(x, 16);
    s = round_shift(y, 16);
    if (neg) begin
      c = -c; s = -s;
    end
    omc = 16384 - c;
    cr[0] = k[1] * v[2] - k[2] * v[1];
    cr[1] = k[2] * v[0] - k[0] * v[2];
    cr[2] = k[0] * v[1] - k[1] * v[0];
    dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
    d16 = round_shift(dot, 14);
    o.saturated = 1'b0;
    for (int j = 0; j < 3; j++) begin
      t1 = v[j] * c;
      t2 = round_shift(cr[j] * s, 14);
      t3 = round_shift(k[j] * d16, 14) * omc;
      sum = round_shift(t1 + t2 + t3, 14);
      if (sum > 64'sd2147483647) begin
        sum = 64'sd2147483647; o.saturated = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        sum = -64'sd2147483648; o.saturated = 1'b1;
      end
      if (j == 0) o.out_x = sum[31:0];
      else if (j == 1) o.out_y = sum[31:0];
      else o.out_z = sum[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 400000)) - 200000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  function automatic aavr_in_t rand_request();
    aavr_in_t r;
    int sel;
    r.in_x = rand_comp();
    r.in_y = rand_comp();
    r.in_z = rand_comp();
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      r.axis_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.axis_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.axis_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else begin
      r.axis_x = 16'($urandom);
      r.axis_y = 16'($urandom);
      r.axis_z = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) r.angle = 16'($urandom);
    else r.angle = 16'($signed($urandom_range(0, 51472)) - 25736);
    return r;
  endfunction

  function automatic aavr_in_t make_req(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [15:0] ang);
    aavr_in_t r;
    r.in_x = x; r.in_y = y; r.in_z = z;
    r.axis_x = ax; r.axis_y = ay; r.axis_z = az; r.angle = ang;
    return r;
  endfunction

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && !in_stall) expected_rot.push_back(rotate_vector(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rot.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", out_data);
        end else begin
          aavr_out_t e;
          e = expected_rot.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                       e.out_x, e.out_y, e.out_z, e.saturated,
                       out_data.out_x, out_data.out_y, out_data.out_z,
                       out_data.saturated);
          end
        end
      end
      if (cycle_count > 400000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rot.size() > 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_reqs.push_back(rand_request());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_reqs.push_back(make_req(32'h00010000, 0, 0, 0, 0, 16'sd16384, 16'sd12868));
    pending_reqs.push_back(make_req(32'h00010000, 32'h00020000, 32'h00030000,
                                    16'sd16384, 0, 0, 16'sd25736));
    pending_reqs.push_back(make_req(32'h00010000, 32'h00020000, 32'h00030000,
                                    0, 16'sd16384, 0, -16'sd25736));
    pending_reqs.push_back(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                    16'sd9459, 16'sd9459, 16'sd9459, 16'sd6434));
    pending_reqs.push_back(make_req(32'h80000000, 32'h80000000, 32'h80000000,
                                    -16'sd16384, 0, 0, 16'sd1));
    pending_reqs.push_back(make_req(32'h7fffffff, 32'h80000000, 0,
                                    0, 0, -16'sd16384, 16'sd12868));
    pending_reqs.push_back(make_req(32'h12345678, 32'h87654321, 32'h0,
                                    16'h7fff, 16'h8000, 16'h7fff, 16'h7fff));
    pending_reqs.push_back(make_req(32'hffffffff, 32'h1, 32'h55555555,
                                    16'hffff, 16'h0, 16'h8000, 16'h8000));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'h00010000, 32'h00010000, 32'h00010000,
                                    0, 0, 0, 16'sd12869));
    pending_reqs.push_back(make_req(32'h00010000, 32'h00010000, 32'h00010000,
                                    16'sd16384, 0, 0, -16'sd12869));
    pending_reqs.push_back(make_req(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                                    16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    drain();

    run_phase(0, 0, 400);
    run_phase(61, 0, 400);
    run_phase(0, 61, 400);
    run_phase(13, 13, 300);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) pending_reqs.push_back(rand_request());
    drain();
    run_phase(0, 0, 390);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
